### src/sdm_pkg.sv
package sdm_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_READ,
    ST_MUL,
    ST_DIV1,
    ST_DIV2
  } state_e;

  typedef enum logic [1:0] {
    OP_CAL,
    OP_ANGLE,
    OP_SPIN,
    OP_STOP
  } op_e;

  typedef enum logic [1:0] {
    DEN_270,
    DEN_180,
    DEN_US
  } den_e;

  localparam logic [2:0] ACT_CAL   = 3'd0;
  localparam logic [2:0] ACT_ANGLE = 3'd1;
  localparam logic [2:0] ACT_SPIN  = 3'd2;
  localparam logic [2:0] ACT_STOP  = 3'd3;
  localparam logic [2:0] ACT_MOVE  = 3'd4;
  localparam logic [2:0] ACT_MOVE2 = 3'd5;
  localparam logic [2:0] ACT_RSTOP = 3'd6;

  localparam logic [2:0] DIR_FWD   = 3'd0;
  localparam logic [2:0] DIR_BACK  = 3'd1;
  localparam logic [2:0] DIR_TURNL = 3'd2;
  localparam logic [2:0] DIR_TURNR = 3'd3;
  localparam logic [2:0] DIR_SPINL = 3'd4;
  localparam logic [2:0] DIR_SPINR = 3'd5;

  localparam logic [2:0] REG_LEFT_PIN  = 3'd0;
  localparam logic [2:0] REG_RIGHT_PIN = 3'd1;
  localparam logic [2:0] REG_DEF_MIN   = 3'd2;
  localparam logic [2:0] REG_DEF_MAX   = 3'd3;

  localparam logic [15:0] DEF_MIN_RST = 16'd1966;
  localparam logic [15:0] DEF_MAX_RST = 16'd7864;
  localparam logic [15:0] DUTY_FULL   = 16'hFFFF;

  localparam logic [8:0] ANGLE_MAX = 9'd270;
  localparam logic [6:0] SPEED_MAX = 7'd100;
  localparam logic [7:0] SPIN_MID  = 8'd90;

  localparam int DIV_SHIFT = 31;
  localparam logic [14:0] DEN_VAL_270 = 15'd270;
  localparam logic [14:0] DEN_VAL_180 = 15'd180;
  localparam logic [14:0] DEN_VAL_US  = 15'd20000;
  localparam logic [23:0] RECIP_270 = 24'((64'd1 << DIV_SHIFT) / 64'd270);
  localparam logic [23:0] RECIP_180 = 24'((64'd1 << DIV_SHIFT) / 64'd180);
  localparam logic [23:0] RECIP_US  = 24'((64'd1 << DIV_SHIFT) / 64'd20000);

  function automatic logic [14:0] den_value(den_e d);
    case (d)
      DEN_270: den_value = DEN_VAL_270;
      DEN_180: den_value = DEN_VAL_180;
      default: den_value = DEN_VAL_US;
    endcase
  endfunction

  function automatic logic [23:0] den_recip(den_e d);
    case (d)
      DEN_270: den_recip = RECIP_270;
      DEN_180: den_recip = RECIP_180;
      default: den_recip = RECIP_US;
    endcase
  endfunction

endpackage

### src/servo_channel_duty_mapper.sv
// One command at a time; busy_o is high from acceptance until the command is done.
// Per wheel: stop or table-full status comes from the lookup alone; angle/spin runs lookup, bounds
// memory read, span multiply, reciprocal multiply, correction; calibrate divides min, then max.
// Robot commands run both wheels back to back, one result per wheel.
// Results are one-cycle strobes on res_valid_o; the receiver cannot stall them.
// Reset (async, active low) empties the channel table and restores register defaults.
module servo_channel_duty_mapper #(
  parameter int CHANNELS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [2:0]         action_i,
  input  logic [5:0]         pin_i,
  input  logic [2:0]         direction_i,
  input  logic signed [10:0] amount_i,
  input  logic signed [10:0] right_speed_i,
  input  logic [14:0]        min_pulse_us_i,
  input  logic [14:0]        max_pulse_us_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  output logic               res_valid_o,
  output logic [5:0]         out_pin_o,
  output logic [2:0]         channel_o,
  output logic [15:0]        duty_o,
  output logic               status_o,
  output logic               last_o
);
  import sdm_pkg::*;

  localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int UW = $clog2(CHANNELS + 1);

  state_e state_q, state_d;

  logic [5:0]  left_pin_q, right_pin_q;
  logic [15:0] def_min_q, def_max_q;
  logic [UW-1:0] used_q, used_d;

  logic [5:0]         pin_tab_q [CHANNELS];
  logic [31:0]        bounds_mem [CHANNELS];
  logic [31:0]        rdata_q;

  op_e                op_q, op_d;
  den_e               den_q, den_d;
  logic               two_q, two_d;
  logic               wsel_q, wsel_d;
  logic               phase_q, phase_d;
  logic [5:0]         wpin_q [2];
  logic [5:0]         wpin_d [2];
  logic               wrev_q [2];
  logic               wrev_d [2];
  logic signed [10:0] wspd_q [2];
  logic signed [10:0] wspd_d [2];
  logic [14:0]        min_us_q, min_us_d, max_us_q, max_us_d;
  logic [IW-1:0]      idx_q, idx_d;
  logic [8:0]         num_q, num_d;
  logic [30:0]        dvd_q, dvd_d;
  logic [54:0]        prod_q, prod_d;
  logic [15:0]        lo_q, lo_d;
  logic [15:0]        cal_min_q, cal_min_d;

  logic        res_valid_q, res_valid_d;
  logic [5:0]  res_pin_q, res_pin_d;
  logic [2:0]  res_chan_q, res_chan_d;
  logic [15:0] res_duty_q, res_duty_d;
  logic        res_status_q, res_status_d;
  logic        res_last_q, res_last_d;

  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;
  logic          mem_re;

  // command decode
  logic               cmd_ok;
  op_e                cmd_op;
  logic               cmd_two;
  logic [5:0]         cmd_pin [2];
  logic               cmd_rev [2];
  logic signed [10:0] cmd_spd [2];

  // lookup
  logic [5:0]    cur_pin;
  logic          cur_rev;
  logic signed [10:0] cur_spd;
  logic          hit;
  logic [IW-1:0] hit_idx;
  logic          full;
  logic          look_fail;
  logic          more;

  // arithmetic
  logic [8:0]         angle_num;
  logic [6:0]         spd_clamp;
  logic [9:0]         spd_x9;
  logic [17:0]        g_full;
  logic [6:0]         g_val;
  logic [7:0]         spin_num;
  logic signed [16:0] span;
  logic signed [26:0] p_mul;
  logic signed [31:0] p_bias;
  logic [23:0]        q_est;
  logic [31:0]        q_back;
  logic [31:0]        q_rem;
  logic [23:0]        q_fix;
  logic [15:0]        q_sat;

  assign busy_o      = (state_q != ST_IDLE);
  // register writes only between commands
  assign cfg_ready_o = (state_q == ST_IDLE) && !start_i;
  assign res_valid_o = res_valid_q;
  assign out_pin_o   = res_pin_q;
  assign channel_o   = res_chan_q;
  assign duty_o      = res_duty_q;
  assign status_o    = res_status_q;
  assign last_o      = res_last_q;

  always_comb begin
    cmd_ok     = 1'b1;
    cmd_op     = OP_SPIN;
    cmd_two    = 1'b0;
    cmd_pin[0] = pin_i;
    cmd_pin[1] = right_pin_q;
    cmd_rev[0] = (direction_i != DIR_FWD);
    cmd_rev[1] = 1'b0;
    cmd_spd[0] = amount_i;
    cmd_spd[1] = amount_i;
    case (action_i)
      ACT_CAL:   cmd_op = OP_CAL;
      ACT_ANGLE: cmd_op = OP_ANGLE;
      ACT_SPIN:  cmd_op = OP_SPIN;
      ACT_STOP:  cmd_op = OP_STOP;
      ACT_MOVE: begin
        cmd_two    = 1'b1;
        cmd_pin[0] = left_pin_q;
        case (direction_i)
          DIR_FWD: begin
            cmd_rev[0] = 1'b0; cmd_rev[1] = 1'b1;
          end
          DIR_BACK: begin
            cmd_rev[0] = 1'b1; cmd_rev[1] = 1'b0;
          end
          DIR_TURNL: begin
            cmd_rev[0] = 1'b0; cmd_rev[1] = 1'b1; cmd_spd[0] = '0;
          end
          DIR_TURNR: begin
            cmd_rev[0] = 1'b0; cmd_rev[1] = 1'b1; cmd_spd[1] = '0;
          end
          DIR_SPINL: begin
            cmd_rev[0] = 1'b1; cmd_rev[1] = 1'b1;
          end
          DIR_SPINR: begin
            cmd_rev[0] = 1'b0; cmd_rev[1] = 1'b0;
          end
          default: cmd_ok = 1'b0;
        endcase
      end
      ACT_MOVE2: begin
        cmd_two    = 1'b1;
        cmd_pin[0] = left_pin_q;
        cmd_spd[1] = right_speed_i;
        case (direction_i)
          DIR_FWD: begin
            cmd_rev[0] = 1'b0; cmd_rev[1] = 1'b1;
          end
          DIR_BACK: begin
            cmd_rev[0] = 1'b1; cmd_rev[1] = 1'b0;
          end
          default: cmd_ok = 1'b0;
        endcase
      end
      ACT_RSTOP: begin
        cmd_op     = OP_STOP;
        cmd_two    = 1'b1;
        cmd_pin[0] = left_pin_q;
      end
      default: cmd_ok = 1'b0;
    endcase
  end

  assign cur_pin = wpin_q[wsel_q];
  assign cur_rev = wrev_q[wsel_q];
  assign cur_spd = wspd_q[wsel_q];
  assign more    = two_q && !wsel_q;
  assign full    = (used_q == UW'(CHANNELS));

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = CHANNELS - 1; i >= 0; i--) begin
      if ((UW'(i) < used_q) && (pin_tab_q[i] == cur_pin)) begin
        hit     = 1'b1;
        hit_idx = IW'(i);
      end
    end
  end

  assign look_fail = !hit && full;

  // clamps and spin angle: g = floor(s*90/100) = floor(9s/10)
  always_comb begin
    if (cur_spd < 0) begin
      angle_num = '0;
      spd_clamp = '0;
    end else begin
      angle_num = (cur_spd > $signed({2'b0, ANGLE_MAX})) ? ANGLE_MAX : cur_spd[8:0];
      spd_clamp = (cur_spd > $signed({4'b0, SPEED_MAX})) ? SPEED_MAX : cur_spd[6:0];
    end
  end

  assign spd_x9   = {3'b0, spd_clamp} * 10'd9;
  assign g_full   = {8'b0, spd_x9} * 18'd205;
  assign g_val    = g_full[17:11];
  assign spin_num = cur_rev ? (SPIN_MID - {1'b0, g_val}) : (SPIN_MID + {1'b0, g_val});

  assign span   = $signed({1'b0, rdata_q[31:16]}) - $signed({1'b0, rdata_q[15:0]});
  assign p_mul  = $signed({18'b0, num_q}) * $signed({{10{span[16]}}, span});
  assign p_bias = 32'(p_mul) + $signed({1'b0, den_value(den_q), 16'b0});

  assign q_est  = prod_q[54:31];
  assign q_back = {8'b0, q_est} * {17'b0, den_value(den_q)};
  assign q_rem  = {1'b0, dvd_q} - q_back;
  assign q_fix  = (q_rem >= {17'b0, den_value(den_q)}) ? (q_est + 24'd1) : q_est;
  assign q_sat  = (|q_fix[23:16]) ? DUTY_FULL : q_fix[15:0];

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i && cmd_ok) state_d = ST_LOOK;
      end
      ST_LOOK: begin
        if (look_fail || op_q == OP_STOP) begin
          state_d = more ? ST_LOOK : ST_IDLE;
        end else if (op_q == OP_CAL) begin
          state_d = ST_DIV1;
        end else begin
          state_d = ST_READ;
        end
      end
      ST_READ: state_d = ST_MUL;
      ST_MUL:  state_d = ST_DIV1;
      ST_DIV1: state_d = ST_DIV2;
      ST_DIV2: begin
        if (op_q == OP_CAL) begin
          state_d = phase_q ? ST_IDLE : ST_DIV1;
        end else begin
          state_d = more ? ST_LOOK : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    used_d    = used_q;
    op_d      = op_q;
    den_d     = den_q;
    two_d     = two_q;
    wsel_d    = wsel_q;
    phase_d   = phase_q;
    wpin_d    = wpin_q;
    wrev_d    = wrev_q;
    wspd_d    = wspd_q;
    min_us_d  = min_us_q;
    max_us_d  = max_us_q;
    idx_d     = idx_q;
    num_d     = num_q;
    dvd_d     = dvd_q;
    prod_d    = prod_q;
    lo_d      = lo_q;
    cal_min_d = cal_min_q;

    res_valid_d  = 1'b0;
    res_pin_d    = res_pin_q;
    res_chan_d   = res_chan_q;
    res_duty_d   = res_duty_q;
    res_status_d = res_status_q;
    res_last_d   = res_last_q;

    mem_we    = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = {def_max_q, def_min_q};
    mem_re    = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          op_d     = cmd_op;
          two_d    = cmd_two;
          wsel_d   = 1'b0;
          wpin_d   = cmd_pin;
          wrev_d   = cmd_rev;
          wspd_d   = cmd_spd;
          min_us_d = min_pulse_us_i;
          max_us_d = max_pulse_us_i;
        end
      end
      ST_LOOK: begin
        if (hit) begin
          idx_d = hit_idx;
        end else if (!full) begin
          idx_d     = used_q[IW-1:0];
          used_d    = used_q + UW'(1);
          mem_we    = 1'b1;
          mem_waddr = used_q[IW-1:0];
        end
        if (look_fail || op_q == OP_STOP) begin
          res_valid_d  = 1'b1;
          res_pin_d    = cur_pin;
          res_chan_d   = look_fail ? 3'd0 : 3'(hit ? hit_idx : used_q[IW-1:0]);
          res_duty_d   = look_fail ? 16'd0 : DUTY_FULL;
          res_status_d = look_fail;
          res_last_d   = !more;
          if (more) wsel_d = 1'b1;
        end
        case (op_q)
          OP_CAL: begin
            den_d   = DEN_US;
            phase_d = 1'b0;
            dvd_d   = {min_us_q, 16'b0} - {16'b0, min_us_q};
          end
          OP_ANGLE: begin
            den_d = DEN_270;
            num_d = angle_num;
          end
          default: begin
            den_d = DEN_180;
            num_d = {1'b0, spin_num};
          end
        endcase
      end
      ST_READ: mem_re = 1'b1;
      ST_MUL: begin
        dvd_d = p_bias[30:0];
        lo_d  = rdata_q[15:0];
      end
      ST_DIV1: prod_d = {24'b0, dvd_q} * {31'b0, den_recip(den_q)};
      ST_DIV2: begin
        if (op_q == OP_CAL) begin
          if (!phase_q) begin
            cal_min_d = q_sat;
            phase_d   = 1'b1;
            dvd_d     = {max_us_q, 16'b0} - {16'b0, max_us_q};
          end else begin
            mem_we    = 1'b1;
            mem_wdata = {q_sat, cal_min_q};
          end
        end else begin
          // bias of den<<16 drops out modulo 2^16
          res_valid_d  = 1'b1;
          res_pin_d    = cur_pin;
          res_chan_d   = 3'(idx_q);
          res_duty_d   = lo_q + q_fix[15:0];
          res_status_d = 1'b0;
          res_last_d   = !more;
          if (more) wsel_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      used_q      <= '0;
      res_valid_q <= 1'b0;
      left_pin_q  <= '0;
      right_pin_q <= '0;
      def_min_q   <= DEF_MIN_RST;
      def_max_q   <= DEF_MAX_RST;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      res_valid_q <= res_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_LEFT_PIN:  left_pin_q  <= cfg_data_i[5:0];
          REG_RIGHT_PIN: right_pin_q <= cfg_data_i[5:0];
          REG_DEF_MIN:   def_min_q   <= cfg_data_i;
          REG_DEF_MAX:   def_max_q   <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    den_q        <= den_d;
    two_q        <= two_d;
    wsel_q       <= wsel_d;
    phase_q      <= phase_d;
    wpin_q       <= wpin_d;
    wrev_q       <= wrev_d;
    wspd_q       <= wspd_d;
    min_us_q     <= min_us_d;
    max_us_q     <= max_us_d;
    idx_q        <= idx_d;
    num_q        <= num_d;
    dvd_q        <= dvd_d;
    prod_q       <= prod_d;
    lo_q         <= lo_d;
    cal_min_q    <= cal_min_d;
    res_pin_q    <= res_pin_d;
    res_chan_q   <= res_chan_d;
    res_duty_q   <= res_duty_d;
    res_status_q <= res_status_d;
    res_last_q   <= res_last_d;
    if (state_q == ST_LOOK && !hit && !full) begin
      pin_tab_q[used_q[IW-1:0]] <= cur_pin;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      bounds_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= bounds_mem[idx_q];
    end
  end

endmodule

### dv/servo_channel_duty_mapper_test.sv
module servo_channel_duty_mapper_test;
  import sdm_pkg::*;

  localparam int CHANNELS      = 8;
  localparam int SETTLE_CYCLES = 16;
  localparam int STALL_LIMIT   = 4000;

  localparam logic [2:0] ACT_NONE = 3'd7;
  localparam logic [2:0] DIR_BAD6 = 3'd6;
  localparam logic [2:0] DIR_BAD7 = 3'd7;
  localparam logic [2:0] REG_NONE = 3'd7;

  typedef struct packed {
    logic [2:0]         action;
    logic [5:0]         pin;
    logic [2:0]         dir;
    logic signed [10:0] amount;
    logic signed [10:0] rspd;
    logic [14:0]        min_us;
    logic [14:0]        max_us;
  } servo_cmd_t;

  typedef struct packed {
    logic [5:0]  pin;
    logic [2:0]  chan;
    logic [15:0] duty;
    logic        status;
    logic        last;
  } duty_word_t;

  typedef struct {
    servo_cmd_t  cmd;
    bit          typed;
    logic [15:0] duty;
  } step_t;

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic [2:0]         action_i = '0;
  logic [5:0]         pin_i = '0;
  logic [2:0]         direction_i = '0;
  logic signed [10:0] amount_i = '0;
  logic signed [10:0] right_speed_i = '0;
  logic [14:0]        min_pulse_us_i = '0;
  logic [14:0]        max_pulse_us_i = '0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i = '0;
  logic [15:0]        cfg_data_i = '0;
  logic               res_valid_o;
  logic [5:0]         out_pin_o;
  logic [2:0]         channel_o;
  logic [15:0]        duty_o;
  logic               status_o;
  logic               last_o;

  servo_channel_duty_mapper #(.CHANNELS(CHANNELS)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .action_i      (action_i),
    .pin_i         (pin_i),
    .direction_i   (direction_i),
    .amount_i      (amount_i),
    .right_speed_i (right_speed_i),
    .min_pulse_us_i(min_pulse_us_i),
    .max_pulse_us_i(max_pulse_us_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .res_valid_o   (res_valid_o),
    .out_pin_o     (out_pin_o),
    .channel_o     (channel_o),
    .duty_o        (duty_o),
    .status_o      (status_o),
    .last_o        (last_o)
  );

  // predictor state
  logic [5:0]  wheel_left = '0;
  logic [5:0]  wheel_right = '0;
  logic [15:0] new_min = 16'd1966;
  logic [15:0] new_max = 16'd7864;
  logic [5:0]  tbl_pin [CHANNELS];
  logic [15:0] tbl_min [CHANNELS];
  logic [15:0] tbl_max [CHANNELS];
  int          tbl_used = 0;

  duty_word_t pending_duty [$];
  step_t      steps [$];
  duty_word_t got;

  int n_cmds = 0;
  int n_words = 0;
  int n_full = 0;
  int n_writes = 0;
  int n_errors = 0;
  int stall_cycles = 0;
  int burst_left = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int lookup_channel(logic [5:0] pin);
    int idx;
    for (int i = 0; i < tbl_used; i++) begin
      if (tbl_pin[i] == pin) return i;
    end
    if (tbl_used >= CHANNELS) return -1;
    idx = tbl_used;
    tbl_used++;
    tbl_pin[idx] = pin;
    tbl_min[idx] = new_min;
    tbl_max[idx] = new_max;
    return idx;
  endfunction

  function automatic int clamp_int(int v, int lo, int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // min + floor(num * (max - min) / den)
  function automatic logic [15:0] span_duty(int idx, longint num, longint den);
    longint mn, p, q;
    mn = longint'(tbl_min[idx]);
    p = num * (longint'(tbl_max[idx]) - mn);
    q = p / den;
    if (p < 0 && q * den != p) q--;
    return 16'(mn + q);
  endfunction

  function automatic logic [15:0] pulse_to_duty(logic [14:0] us);
    longint d;
    d = 65535 * longint'(us) / 20000;
    return d > 65535 ? 16'hFFFF : 16'(d);
  endfunction

  function automatic void push_word(logic [5:0] pin, int idx, logic [15:0] duty);
    duty_word_t w;
    w.pin = pin;
    w.last = 1'b0;
    if (idx < 0) begin
      w.chan = '0;
      w.duty = '0;
      w.status = 1'b1;
    end else begin
      w.chan = 3'(idx);
      w.duty = duty;
      w.status = 1'b0;
    end
    pending_duty.push_back(w);
  endfunction

  function automatic void wheel_spin(logic [5:0] pin, bit rev, int spd);
    int idx, g;
    idx = lookup_channel(pin);
    g = clamp_int(spd, 0, 100) * 90 / 100;
    push_word(pin, idx, idx < 0 ? 16'd0 : span_duty(idx, rev ? 90 - g : 90 + g, 180));
  endfunction

  function automatic void wheel_stop(logic [5:0] pin);
    push_word(pin, lookup_channel(pin), 16'hFFFF);
  endfunction

  function automatic int predict_command(servo_cmd_t c);
    int n0, idx, amt, rs;
    duty_word_t w;
    n0 = pending_duty.size();
    amt = int'(c.amount);
    rs = int'(c.rspd);
    case (c.action)
      ACT_CAL: begin
        idx = lookup_channel(c.pin);
        if (idx < 0) begin
          push_word(c.pin, idx, 16'd0);
        end else begin
          tbl_min[idx] = pulse_to_duty(c.min_us);
          tbl_max[idx] = pulse_to_duty(c.max_us);
        end
      end
      ACT_ANGLE: begin
        idx = lookup_channel(c.pin);
        push_word(c.pin, idx, idx < 0 ? 16'd0 : span_duty(idx, clamp_int(amt, 0, 270), 270));
      end
      ACT_SPIN: wheel_spin(c.pin, c.dir != DIR_FWD, amt);
      ACT_STOP: wheel_stop(c.pin);
      ACT_MOVE: begin
        case (c.dir)
          DIR_FWD: begin
            wheel_spin(wheel_left, 0, amt);
            wheel_spin(wheel_right, 1, amt);
          end
          DIR_BACK: begin
            wheel_spin(wheel_left, 1, amt);
            wheel_spin(wheel_right, 0, amt);
          end
          DIR_TURNL: begin
            wheel_spin(wheel_left, 0, 0);
            wheel_spin(wheel_right, 1, amt);
          end
          DIR_TURNR: begin
            wheel_spin(wheel_left, 0, amt);
            wheel_spin(wheel_right, 1, 0);
          end
          DIR_SPINL: begin
            wheel_spin(wheel_left, 1, amt);
            wheel_spin(wheel_right, 1, amt);
          end
          DIR_SPINR: begin
            wheel_spin(wheel_left, 0, amt);
            wheel_spin(wheel_right, 0, amt);
          end
          default: ;
        endcase
      end
      ACT_MOVE2: begin
        if (c.dir == DIR_FWD) begin
          wheel_spin(wheel_left, 0, amt);
          wheel_spin(wheel_right, 1, rs);
        end else if (c.dir == DIR_BACK) begin
          wheel_spin(wheel_left, 1, amt);
          wheel_spin(wheel_right, 0, rs);
        end
      end
      ACT_RSTOP: begin
        wheel_stop(wheel_left);
        wheel_stop(wheel_right);
      end
      default: ;
    endcase
    if (pending_duty.size() > n0) begin
      w = pending_duty.pop_back();
      w.last = 1'b1;
      pending_duty.push_back(w);
    end
    return pending_duty.size() - n0;
  endfunction

  function automatic void add_step(logic [2:0] action, logic [5:0] pin, logic [2:0] dir,
                                   int amount, int rspd, int min_us, int max_us,
                                   bit typed, logic [15:0] duty);
    step_t s;
    s.cmd.action = action;
    s.cmd.pin = pin;
    s.cmd.dir = dir;
    s.cmd.amount = 11'(amount);
    s.cmd.rspd = 11'(rspd);
    s.cmd.min_us = 15'(min_us);
    s.cmd.max_us = 15'(max_us);
    s.typed = typed;
    s.duty = duty;
    steps.push_back(s);
  endfunction

  function automatic logic [5:0] pick_pin(int cap);
    if (tbl_used > 0 && ($urandom_range(0, 99) < 85 || (tbl_used >= cap && tbl_used < CHANNELS)))
      return tbl_pin[$urandom_range(0, tbl_used - 1)];
    return ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 39));
  endfunction

  function automatic logic signed [10:0] random_speed();
    int r;
    r = $urandom_range(0, 4);
    if (r < 3) return 11'($urandom_range(0, 300));
    if (r == 3) return 11'(int'($urandom_range(0, 140)) - 20);
    return 11'(int'($urandom_range(0, 2047)) - 1024);
  endfunction

  function automatic servo_cmd_t random_command(int cap);
    servo_cmd_t c;
    c.action = ($urandom_range(0, 99) < 2) ? ACT_NONE : 3'($urandom_range(ACT_CAL, ACT_RSTOP));
    c.pin = pick_pin(cap);
    case (c.action)
      ACT_MOVE:  c.dir = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(DIR_BAD6, DIR_BAD7))
                                                     : 3'($urandom_range(DIR_FWD, DIR_SPINR));
      ACT_MOVE2: c.dir = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(DIR_TURNL, DIR_BAD7))
                                                     : 3'($urandom_range(DIR_FWD, DIR_BACK));
      default:   c.dir = 3'($urandom_range(0, 7));
    endcase
    c.amount = random_speed();
    c.rspd = random_speed();
    c.min_us = ($urandom_range(0, 9) == 0) ? 15'($urandom_range(0, 32767))
                                           : 15'($urandom_range(0, 20000));
    c.max_us = ($urandom_range(0, 9) == 0) ? 15'($urandom_range(0, 32767))
                                           : 15'($urandom_range(0, 20000));
    return c;
  endfunction

  task automatic send_command(input servo_cmd_t c, output int added);
    action_i <= c.action;
    pin_i <= c.pin;
    direction_i <= c.dir;
    amount_i <= c.amount;
    right_speed_i <= c.rspd;
    min_pulse_us_i <= c.min_us;
    max_pulse_us_i <= c.max_us;
    start_i <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    added = predict_command(c);
    n_cmds++;
  endtask

  task automatic pause_between();
    int r, gap;
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 2) burst_left = $urandom_range(30, 60);
      gap = r < 45 ? 0 : r < 80 ? $urandom_range(1, 3) :
            r < 96 ? $urandom_range(4, 12) : $urandom_range(20, 40);
    end
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    start_i <= 1'b0;
    while (pending_duty.size() != 0) @(posedge clk_i);
    // calibrate and dropped robot words leave nothing to wait on
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_LEFT_PIN:  wheel_left = data[5:0];
      REG_RIGHT_PIN: wheel_right = data[5:0];
      REG_DEF_MIN:   new_min = data;
      REG_DEF_MAX:   new_max = data;
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    n_writes++;
  endtask

  task automatic run_random(int count, int cap);
    int done, k;
    servo_cmd_t c;
    done = 0;
    while (done < count) begin
      c = random_command(cap);
      send_command(c, k);
      if (!(c.action == ACT_NONE || (c.action == ACT_MOVE && c.dir > DIR_SPINR) ||
            (c.action == ACT_MOVE2 && c.dir > DIR_BACK)))
        done++;
      pause_between();
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      n_words++;
      if (status_o) n_full++;
      if (pending_duty.size() == 0) begin
        if (n_errors < 10) $display("ERROR: unexpected duty word for pin %0d", out_pin_o);
        n_errors++;
      end else begin
        got = pending_duty.pop_front();
        if (out_pin_o !== got.pin || channel_o !== got.chan || duty_o !== got.duty ||
            status_o !== got.status || last_o !== got.last) begin
          if (n_errors < 10)
            $display("ERROR: pin/ch/duty/st/last exp %0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d",
                     got.pin, got.chan, got.duty, got.status, got.last,
                     out_pin_o, channel_o, duty_o, status_o, last_o);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || res_valid_o || (cfg_valid_i && cfg_ready_o))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("ERROR: no progress for %0d cycles", STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int k, base;
    duty_word_t w;
    logic [5:0] p;

    // reset bounds 1966..7864, both wheels on pin 0
    add_step(ACT_STOP,  6'd5,  DIR_FWD,  0,     0,    0,     0,     1, 16'hFFFF);
    add_step(ACT_ANGLE, 6'd5,  DIR_FWD,  0,     0,    0,     0,     1, 16'd1966);
    add_step(ACT_ANGLE, 6'd5,  DIR_FWD,  270,   0,    0,     0,     1, 16'd7864);
    add_step(ACT_ANGLE, 6'd5,  DIR_FWD,  1023,  0,    0,     0,     1, 16'd7864);
    add_step(ACT_ANGLE, 6'd5,  DIR_FWD,  -1024, 0,    0,     0,     1, 16'd1966);
    add_step(ACT_SPIN,  6'd39, DIR_FWD,  100,   0,    0,     0,     1, 16'd7864);
    add_step(ACT_SPIN,  6'd39, DIR_BACK, 100,   0,    0,     0,     1, 16'd1966);
    add_step(ACT_SPIN,  6'd39, DIR_FWD,  -1024, 0,    0,     0,     1, 16'd4915);
    add_step(ACT_CAL,   6'd5,  DIR_FWD,  0,     0,    0,     20000, 0, 16'd0);
    add_step(ACT_ANGLE, 6'd5,  DIR_FWD,  270,   0,    0,     0,     1, 16'hFFFF);
    // saturated min above max: inverted span
    add_step(ACT_CAL,   6'd5,  DIR_FWD,  0,     0,    32767, 0,     0, 16'd0);
    add_step(ACT_ANGLE, 6'd5,  DIR_FWD,  90,    0,    0,     0,     0, 16'd0);
    add_step(ACT_RSTOP, 6'd0,  DIR_FWD,  0,     0,    0,     0,     1, 16'hFFFF);
    add_step(ACT_MOVE,  6'd0,  DIR_FWD,  60,    0,    0,     0,     0, 16'd0);
    add_step(ACT_MOVE,  6'd0,  DIR_BACK, 100,   0,    0,     0,     0, 16'd0);
    add_step(ACT_MOVE,  6'd0,  DIR_TURNL, 1023, 0,    0,     0,     0, 16'd0);
    add_step(ACT_MOVE,  6'd0,  DIR_TURNR, -1024, 0,   0,     0,     0, 16'd0);
    add_step(ACT_MOVE,  6'd0,  DIR_SPINL, 37,   0,    0,     0,     0, 16'd0);
    add_step(ACT_MOVE,  6'd0,  DIR_SPINR, 100,  0,    0,     0,     0, 16'd0);
    add_step(ACT_MOVE,  6'd0,  DIR_BAD6, 50,    0,    0,     0,     0, 16'd0);
    add_step(ACT_MOVE2, 6'd0,  DIR_FWD,  100,   -5,   0,     0,     0, 16'd0);
    add_step(ACT_MOVE2, 6'd0,  DIR_BACK, -1024, 1023, 0,     0,     0, 16'd0);
    add_step(ACT_MOVE2, 6'd0,  DIR_BAD7, 50,    50,   0,     0,     0, 16'd0);
    add_step(ACT_NONE,  6'd63, DIR_BAD7, 1023,  1023, 32767, 32767, 0, 16'd0);
    add_step(ACT_CAL,   6'd32, DIR_FWD,  0,     0,    1000,  2000,  0, 16'd0);
    add_step(ACT_SPIN,  6'd32, DIR_BAD7, 45,    0,    0,     0,     0, 16'd0);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (steps[i]) begin
      send_command(steps[i].cmd, k);
      if (steps[i].typed) begin
        base = pending_duty.size() - k;
        for (int j = 0; j < k; j++) begin
          w = pending_duty[base + j];
          w.duty = steps[i].duty;
          pending_duty[base + j] = w;
        end
      end
      pause_between();
    end

    // inverted extreme defaults; leave room for two more channels
    wait_idle();
    write_reg(REG_LEFT_PIN, 16'hFFE7);
    write_reg(REG_RIGHT_PIN, 16'd32);
    write_reg(REG_DEF_MIN, 16'hFFFF);
    write_reg(REG_DEF_MAX, 16'h0000);
    run_random(300, 6);

    // full-range defaults for the remaining channels
    wait_idle();
    write_reg(REG_LEFT_PIN, 16'(tbl_pin[$urandom_range(0, tbl_used - 1)]));
    write_reg(REG_RIGHT_PIN, 16'(tbl_pin[$urandom_range(0, tbl_used - 1)]));
    write_reg(REG_DEF_MIN, 16'h0000);
    write_reg(REG_DEF_MAX, 16'hFFFF);
    run_random(300, CHANNELS);

    // both wheels on one pin
    wait_idle();
    p = 6'($urandom_range(0, 39));
    write_reg(REG_NONE, 16'($urandom));
    write_reg(REG_LEFT_PIN, 16'(p));
    write_reg(REG_RIGHT_PIN, 16'(p));
    write_reg(REG_DEF_MIN, 16'($urandom));
    write_reg(REG_DEF_MAX, 16'($urandom));
    run_random(300, CHANNELS);

    wait_idle();
    write_reg(REG_LEFT_PIN, 16'($urandom));
    write_reg(REG_RIGHT_PIN, 16'($urandom));
    write_reg(REG_DEF_MIN, 16'($urandom));
    write_reg(REG_DEF_MAX, 16'($urandom));
    run_random(325, CHANNELS);

    wait_idle();
    $display("Ran %0d commands, compared %0d duty words, %0d of them table-full status",
             n_cmds, n_words, n_full);
    $display("%0d register writes, %0d channels allocated, %0d mismatches",
             n_writes, tbl_used, n_errors);
    if (n_errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
